[rtl/core/ibd_pkg.sv]
// Shared constants and control/status types for the window intersection scanner.
package ibd_pkg;

  // Default sizing handed to the top level
  localparam int LANES_DEF    = 64;
  localparam int POS_BITS_DEF = 20;

  // Fixed field widths
  localparam int WORD_W     = 64;
  localparam int GENO_W     = 2;
  localparam int WLEN_W     = 10;
  localparam int MINLEN_W   = 20;
  localparam int SLOT_W     = 7;
  localparam int LANE_W     = 6;
  localparam int OUT_POS_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Homozygous-alternate genotype code, the only one that intersects
  localparam logic [GENO_W-1:0] GENO_HOM = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCH_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_SLOT        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LANES     = 2'd3;

  // Configuration reset values
  localparam logic [WLEN_W-1:0]   WLEN_RST   = 10'd200;
  localparam logic [MINLEN_W-1:0] MINLEN_RST = 20'd800;
  localparam logic [SLOT_W-1:0]   SLOT_RST   = 7'd64;
  localparam logic [SLOT_W-1:0]   ACTIVE_RST = 7'd64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;        // accept one marker request
    logic step;        // advance the lane walk by one lane
    logic load_pend;   // capture the head lane as the pending result
    logic pend_to_out; // move the pending result into the output register
    logic final_res;   // mark the moved result as the last of the report
    logic clear;       // return scan state to its reset value
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic qual;        // head lane of the walk is reportable
    logic pend_valid;  // a pending result is held
    logic out_free;    // output register can take a result this cycle
    logic walk_done;   // every lane has been visited
  } dp_status_t;

endpackage

[rtl/core/ibd_channels.sv]
// Handshake channel interfaces for marker input, result output and configuration.
interface ibd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ibd_pkg::GENO_W-1:0]    focal_genotype;
  logic [ibd_pkg::WORD_W-1:0]    compat_word;
  logic                          last_marker;

  modport source (output valid, focal_genotype, compat_word, last_marker, input ready);
  modport sink   (input valid, focal_genotype, compat_word, last_marker, output ready);
endinterface

interface ibd_out_if;
  logic                           valid;
  logic                           ready;
  logic [ibd_pkg::LANE_W-1:0]     lane;
  logic [ibd_pkg::OUT_POS_W-1:0]  run_start;
  logic [ibd_pkg::OUT_POS_W-1:0]  run_end;
  logic                           final_res;

  modport source (output valid, lane, run_start, run_end, final_res, input ready);
  modport sink   (input valid, lane, run_start, run_end, final_res, output ready);
endinterface

interface ibd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ibd_pkg::CFG_IDX_W-1:0]   index;
  logic [ibd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ibd_window_intersection_scanner.sv]
// Top level: windowed intersection scanner for shared runs against a group of lanes.
// Throughput: one marker request per cycle while no report is in progress.
// A last marker starts a report: the walk visits one lane per cycle while no result-side stall
// holds it, then a flush state ends the report; no marker is taken meanwhile.
// A match waits as pending until the next match or the flush, then moves into the output
// register once it is free; result-side stalls lengthen the walk. Reset (rst_n low,
// synchronous) restores register defaults and clears window, lane and result flags and the walk counter.
module ibd_window_intersection_scanner #(
  parameter int LANES    = ibd_pkg::LANES_DEF,
  parameter int POS_BITS = ibd_pkg::POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ibd_in_if.sink     in_ch,
  ibd_out_if.source  out_ch,
  ibd_cfg_if.sink    cfg_ch
);

  ibd_pkg::ctrl_cmd_t  cmd;
  ibd_pkg::dp_status_t status;
  logic                in_ready;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Sequence intake, walk and flush
  ibd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_marker),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold window, lane and report state
  ibd_datapath #(
    .LANES    (LANES),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .focal_genotype (in_ch.focal_genotype),
    .compat_word    (in_ch.compat_word),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_lane       (out_ch.lane),
    .out_run_start  (out_ch.run_start),
    .out_run_end    (out_ch.run_end),
    .out_final_res  (out_ch.final_res)
  );

endmodule

[rtl/core/ibd_ctrl.sv]
// Controller state machine: marker intake, lane walk and report flush.
module ibd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  ibd_pkg::dp_status_t status,
  output ibd_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_nxt = ST_FLUSH;
        end else if (!status.qual) begin
          cmd.step = 1'b1;
        end else if (!status.pend_valid) begin
          cmd.step      = 1'b1;
          cmd.load_pend = 1'b1;
        end else if (status.out_free) begin
          // push the older match out, keep the new one pending
          cmd.step        = 1'b1;
          cmd.load_pend   = 1'b1;
          cmd.pend_to_out = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.pend_to_out = 1'b1;
          cmd.final_res   = 1'b1;
          cmd.clear       = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/ibd_datapath.sv]
// Datapath: configuration registers, window intersection, lane runs and report registers.
module ibd_datapath #(
  parameter int LANES    = ibd_pkg::LANES_DEF,
  parameter int POS_BITS = ibd_pkg::POS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ibd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ibd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // marker payload
  input  logic [ibd_pkg::GENO_W-1:0]        focal_genotype,
  input  logic [ibd_pkg::WORD_W-1:0]        compat_word,
  // control
  input  ibd_pkg::ctrl_cmd_t                cmd,
  output ibd_pkg::dp_status_t               status,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ibd_pkg::LANE_W-1:0]        out_lane,
  output logic [ibd_pkg::OUT_POS_W-1:0]     out_run_start,
  output logic [ibd_pkg::OUT_POS_W-1:0]     out_run_end,
  output logic                              out_final_res
);

  localparam int SUM_W = (POS_BITS > ibd_pkg::WLEN_W) ? POS_BITS : ibd_pkg::WLEN_W;
  localparam int CMP_W = (POS_BITS > ibd_pkg::MINLEN_W) ? POS_BITS : ibd_pkg::MINLEN_W;
  localparam logic [ibd_pkg::SLOT_W-1:0] LANE_CNT = ibd_pkg::SLOT_W'(LANES);

  // configuration
  logic [ibd_pkg::WLEN_W-1:0]   wlen_r;
  logic [ibd_pkg::MINLEN_W-1:0] min_len_r;
  logic [ibd_pkg::SLOT_W-1:0]   self_slot_r;
  logic [ibd_pkg::SLOT_W-1:0]   act_lanes_r;

  // window and lane state
  logic [ibd_pkg::WORD_W-1:0]   win_and_r;
  logic [ibd_pkg::WLEN_W-1:0]   win_fill_r;
  logic [POS_BITS-1:0]          win_base_r;
  logic [LANES-1:0]             lane_open_r;
  logic [POS_BITS-1:0]          lane_start_r [LANES];
  logic [ibd_pkg::SLOT_W-1:0]   idx_r;

  // pending and output result
  logic                         pend_valid_r;
  logic [ibd_pkg::LANE_W-1:0]   pend_lane_r;
  logic [ibd_pkg::OUT_POS_W-1:0] pend_start_r;
  logic                         out_valid_r;
  logic [ibd_pkg::LANE_W-1:0]   out_lane_r;
  logic [ibd_pkg::OUT_POS_W-1:0] out_start_r;
  logic [ibd_pkg::OUT_POS_W-1:0] out_end_r;
  logic                         out_final_r;

  // combinational
  logic [ibd_pkg::WLEN_W-1:0]   wlen_eff;
  logic [ibd_pkg::WORD_W-1:0]   and_nxt;
  logic [ibd_pkg::WLEN_W-1:0]   fill_inc;
  logic                         close;
  logic [SUM_W-1:0]             base_sum;
  logic [POS_BITS-1:0]          head_len;
  logic [CMP_W-1:0]             head_len_ext;
  logic [CMP_W-1:0]             base_ext;
  logic [CMP_W-1:0]             head_start_ext;
  logic                         out_free;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= ibd_pkg::WLEN_RST;
      min_len_r   <= ibd_pkg::MINLEN_RST;
      self_slot_r <= ibd_pkg::SLOT_RST;
      act_lanes_r <= ibd_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ibd_pkg::REG_WINDOW_LENGTH:    wlen_r      <= cfg_data[ibd_pkg::WLEN_W-1:0];
        ibd_pkg::REG_MIN_MATCH_LENGTH: min_len_r   <= cfg_data[ibd_pkg::MINLEN_W-1:0];
        ibd_pkg::REG_SELF_SLOT:        self_slot_r <= cfg_data[ibd_pkg::SLOT_W-1:0];
        ibd_pkg::REG_ACTIVE_LANES:     act_lanes_r <= cfg_data[ibd_pkg::SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Window intersection and close decision
  always_comb begin
    wlen_eff = (wlen_r == '0) ? ibd_pkg::WLEN_W'(1) : wlen_r;
    and_nxt  = (focal_genotype == ibd_pkg::GENO_HOM) ? (win_and_r & compat_word) : win_and_r;
    fill_inc = win_fill_r + ibd_pkg::WLEN_W'(1);
    close    = (fill_inc >= wlen_eff);
    base_sum = SUM_W'(win_base_r) + SUM_W'(fill_inc);
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      win_and_r  <= '1;
      win_fill_r <= '0;
      win_base_r <= '0;
    end else if (cmd.take) begin
      if (close) begin
        win_and_r  <= '1;
        win_fill_r <= '0;
        win_base_r <= base_sum[POS_BITS-1:0];
      end else begin
        win_and_r  <= and_nxt;
        win_fill_r <= fill_inc;
      end
    end
  end

  // Lane run flags: update in parallel at window close, shift down during the walk
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      lane_open_r <= '0;
    end else if (cmd.step) begin
      lane_open_r <= lane_open_r >> 1;
    end else if (cmd.take && close) begin
      for (int i = 0; i < LANES; i++) begin
        lane_open_r[i] <= and_nxt[ibd_pkg::WORD_W-1-i];
      end
    end
  end

  // Lane run starts
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int i = 0; i < LANES - 1; i++) begin
        lane_start_r[i] <= lane_start_r[i+1];
      end
    end else if (cmd.take && close) begin
      for (int i = 0; i < LANES; i++) begin
        if (and_nxt[ibd_pkg::WORD_W-1-i] && !lane_open_r[i]) begin
          lane_start_r[i] <= win_base_r;
        end
      end
    end
  end

  // Walk lane counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + ibd_pkg::SLOT_W'(1);
    end
  end

  // Evaluate the head lane of the walk
  always_comb begin
    head_len       = win_base_r - lane_start_r[0];
    head_len_ext   = CMP_W'(head_len);
    base_ext       = CMP_W'(win_base_r);
    head_start_ext = CMP_W'(lane_start_r[0]);
    out_free       = !out_valid_r || out_ready;
    status.qual       = lane_open_r[0] && (idx_r < act_lanes_r) && (idx_r != self_slot_r)
                        && (head_len_ext >= CMP_W'(min_len_r));
    status.pend_valid = pend_valid_r;
    status.out_free   = out_free;
    status.walk_done  = (idx_r == LANE_CNT);
  end

  // Pending result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load_pend) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.pend_to_out) begin
      pend_valid_r <= 1'b0;
    end
  end

  // Pending result payload
  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_lane_r  <= idx_r[ibd_pkg::LANE_W-1:0];
      pend_start_r <= head_start_ext[ibd_pkg::OUT_POS_W-1:0];
    end
  end

  // Output register flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pend_to_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.pend_to_out) begin
      out_lane_r  <= pend_lane_r;
      out_start_r <= pend_start_r;
      out_end_r   <= base_ext[ibd_pkg::OUT_POS_W-1:0];
      out_final_r <= cmd.final_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lane      = out_lane_r;
  assign out_run_start = out_start_r;
  assign out_run_end   = out_end_r;
  assign out_final_res = out_final_r;

endmodule
